// ===== src/fcrm_pkg.sv =====
// Shared constants, codes and handshake structs of the floppy controller register model.
// No dependencies.
package fcrm_pkg;

  localparam int SectorBytesDef = 512;
  localparam int DiskBytesDef   = 1048576;
  localparam int StepLimit      = 80;
  localparam int AddrFieldLen   = 6;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  localparam logic [1:0] REG_CMD    = 2'd0;
  localparam logic [1:0] REG_TRACK  = 2'd1;
  localparam logic [1:0] REG_SECTOR = 2'd2;
  localparam logic [1:0] REG_DATA   = 2'd3;

  localparam logic [1:0] CFG_DISK    = 2'd0;
  localparam logic [1:0] CFG_TRACKS  = 2'd1;
  localparam logic [1:0] CFG_HEADS   = 2'd2;
  localparam logic [1:0] CFG_SECTORS = 2'd3;

  localparam logic [3:0] CMD_RESTORE  = 4'h0;
  localparam logic [3:0] CMD_SEEK     = 4'h1;
  localparam logic [3:0] CMD_STEP_OUT_A = 4'h2;
  localparam logic [3:0] CMD_STEP     = 4'h3;
  localparam logic [3:0] CMD_STEP_IN_A  = 4'h4;
  localparam logic [3:0] CMD_STEP_OUT_B = 4'h5;
  localparam logic [3:0] CMD_STEP_IN_B  = 4'h6;
  localparam logic [3:0] CMD_STEP_OUT_C = 4'h7;
  localparam logic [3:0] CMD_READ     = 4'h8;
  localparam logic [3:0] CMD_WRITE    = 4'ha;
  localparam logic [3:0] CMD_RD_ADDR  = 4'hc;
  localparam logic [3:0] CMD_FORCE_IRQ = 4'hd;

  typedef enum logic [1:0] {
    COPY_DISK2BUF,
    COPY_ADDR,
    COPY_BUF2DISK
  } copy_mode_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_fin;
    logic copy_rd;
    logic copy_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       need_rdbuf;
    logic       need_copy;
    copy_mode_e mode;
  } dp_status_t;

  function automatic logic [7:0] size_code(input int sb);
    int n;
    n = 0;
    while (n < 3 && (128 << n) < sb) n++;
    return 8'(n);
  endfunction

endpackage

// ===== src/floppy_controller_register_model_unit.sv =====
// Register and load accesses just execute, a data read reads the transfer buffer, read
// sector and the final data write of write sector copy a sector between image memory
// and buffer (one byte a cycle through the image memory port), read address copies the
// address field. One item at a time. Reset restores all registers to their
// power-on values; buffer and image memories are not cleared and need no clearing pass.
module floppy_controller_register_model_unit #(
  parameter int SECTOR_BYTES = fcrm_pkg::SectorBytesDef,
  parameter int DISK_BYTES   = fcrm_pkg::DiskBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  reg_index_i,
  input  logic [7:0]  write_value_i,
  input  logic        side_i,
  input  logic [1:0]  drive_i,
  input  logic [19:0] image_address_i,
  input  logic [7:0]  image_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        irq_line_o,
  output logic        drq_line_o,
  output logic        busy_flag_o
);
  import fcrm_pkg::*;

  localparam int CW = $clog2(SECTOR_BYTES + 1);

  ctrl_cmd_t     cmd;
  dp_status_t    status;
  logic [CW-1:0] copy_idx;

  assign cfg_ready_o = 1'b1;

  fcrm_ctrl #(.SECTOR_BYTES(SECTOR_BYTES), .CW(CW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd), .copy_idx_o(copy_idx)
  );

  fcrm_datapath #(.SECTOR_BYTES(SECTOR_BYTES), .DISK_BYTES(DISK_BYTES), .CW(CW)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i & cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .kind_i, .reg_index_i, .write_value_i, .side_i, .drive_i, .image_address_i,
    .image_byte_i, .cmd_i(cmd), .copy_idx_i(copy_idx), .status_o(status),
    .read_data_o, .irq_line_o, .drq_line_o, .busy_flag_o
  );

endmodule

// ===== src/fcrm_ctrl.sv =====
// Sequencer of the floppy controller register model: handshakes, execute, copy loop.
// Depends on fcrm_pkg.
module fcrm_ctrl #(
  parameter int SECTOR_BYTES = fcrm_pkg::SectorBytesDef,
  parameter int CW           = $clog2(SECTOR_BYTES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  fcrm_pkg::dp_status_t  status_i,
  output fcrm_pkg::ctrl_cmd_t   cmd_o,
  output logic [CW-1:0]         copy_idx_o
);
  import fcrm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RDBUF = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  copy_mode_e    mode_q, mode_d;
  logic [CW-1:0] len;

  assign len        = (mode_q == COPY_ADDR) ? CW'(AddrFieldLen) : CW'(SECTOR_BYTES);
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign copy_idx_o = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        cnt_d      = '0;
        mode_d     = status_i.mode;
        if (status_i.need_rdbuf) state_d = S_RDBUF;
        else if (status_i.need_copy) state_d = S_COPY;
        else state_d = S_DONE;
      end
      S_RDBUF: begin
        cmd_o.rd_fin = 1'b1;
        state_d      = S_DONE;
      end
      S_COPY: begin
        cmd_o.copy_rd = (cnt_q < len);
        cmd_o.copy_wr = (cnt_q != '0);
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == len) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mode_q  <= COPY_DISK2BUF;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
    end
  end

endmodule

// ===== src/fcrm_datapath.sv =====
// Registers, geometry lookup, transfer buffer and disk image memory of the controller.
// Depends on fcrm_pkg; driven by fcrm_ctrl commands.
module fcrm_datapath #(
  parameter int SECTOR_BYTES = fcrm_pkg::SectorBytesDef,
  parameter int DISK_BYTES   = fcrm_pkg::DiskBytesDef,
  parameter int CW           = $clog2(SECTOR_BYTES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic [1:0]           kind_i,
  input  logic [1:0]           reg_index_i,
  input  logic [7:0]           write_value_i,
  input  logic                 side_i,
  input  logic [1:0]           drive_i,
  input  logic [19:0]          image_address_i,
  input  logic [7:0]           image_byte_i,
  input  fcrm_pkg::ctrl_cmd_t  cmd_i,
  input  logic [CW-1:0]        copy_idx_i,
  output fcrm_pkg::dp_status_t status_o,
  output logic [7:0]           read_data_o,
  output logic                 irq_line_o,
  output logic                 drq_line_o,
  output logic                 busy_flag_o
);
  import fcrm_pkg::*;

  localparam int BW  = $clog2(SECTOR_BYTES);
  localparam int DAW = $clog2(DISK_BYTES);

  logic       disk_present_q;
  logic [6:0] track_count_q;
  logic [1:0] head_count_q;
  logic [3:0] spt_q;

  logic [1:0]  kind_q, reg_q, drive_q;
  logic [7:0]  val_q, byte_q;
  logic        side_q;
  logic [19:0] addr_q;

  logic [7:0] track_q, sector_q, data_q, rd_q;
  logic       nf_q, drq_q, irq_q, busy_q, t1_q, wr_mode_q, toggle_q;
  logic [CW-1:0] len_q, pos_q;
  logic [DAW-1:0] off_q;
  copy_mode_e mode_q;

  logic [7:0] buf_mem [SECTOR_BYTES];
  logic [7:0] disk_mem [DISK_BYTES];
  logic [7:0] buf_rd_q, disk_rd_q;

  // geometry lookup
  logic        loc_ok;
  logic [14:0] blk;
  logic [31:0] off_w;
  always_comb begin
    blk   = 15'((15'(track_q[6:0]) * 15'(head_count_q) + 15'(side_q)) * 15'(spt_q)
            + 15'(sector_q[3:0] - 4'd1));
    off_w = 32'(blk) * 32'(SECTOR_BYTES);
    loc_ok = disk_present_q && (drive_q == 2'd0) && (track_q < {1'b0, track_count_q})
             && ({1'b0, side_q} < head_count_q) && (sector_q != 8'd0)
             && (sector_q <= {4'd0, spt_q})
             && ({1'b0, off_w} + 33'(SECTOR_BYTES) <= 33'(DISK_BYTES));
  end

  logic [3:0] cmdn;
  logic       in_buf;
  logic [CW-1:0] pos_inc, pos_new;
  logic       cmd_xfer, is_dwrite;
  assign cmdn     = val_q[7:4];
  assign in_buf   = (pos_q < len_q);
  assign pos_inc  = pos_q + 1'b1;
  assign pos_new  = in_buf ? pos_inc : pos_q;
  assign cmd_xfer = (cmdn == CMD_READ) || (cmdn == CMD_WRITE) || (cmdn == CMD_RD_ADDR);
  assign is_dwrite = (kind_q == KIND_WRITE) && (reg_q == REG_DATA) && wr_mode_q;

  always_comb begin
    status_o = '0;
    status_o.need_rdbuf = (kind_q == KIND_READ) && (reg_q == REG_DATA) && in_buf;
    status_o.mode = COPY_DISK2BUF;
    if (kind_q == KIND_WRITE && reg_q == REG_CMD && cmd_xfer && loc_ok &&
        cmdn != CMD_WRITE) begin
      status_o.need_copy = 1'b1;
      status_o.mode = (cmdn == CMD_RD_ADDR) ? COPY_ADDR : COPY_DISK2BUF;
    end else if (is_dwrite && pos_new >= len_q && loc_ok) begin
      status_o.need_copy = 1'b1;
      status_o.mode = COPY_BUF2DISK;
    end
  end

  logic [7:0] status_v;
  always_comb begin
    status_v    = '0;
    status_v[7] = !disk_present_q || (drive_q != 2'd0);
    status_v[0] = busy_q;
    if (t1_q) begin
      status_v[5] = 1'b1;
      status_v[2] = (track_q == 8'd0);
      status_v[1] = !toggle_q;
    end else begin
      status_v[4] = nf_q;
      status_v[1] = drq_q;
    end
  end

  // address mark field for read address
  logic [CW-1:0] widx;
  logic [7:0]    addr_byte;
  assign widx = copy_idx_i - 1'b1;
  always_comb begin
    case (widx[2:0])
      3'd0:    addr_byte = track_q;
      3'd1:    addr_byte = {7'd0, side_q};
      3'd2:    addr_byte = sector_q;
      3'd3:    addr_byte = size_code(SECTOR_BYTES);
      default: addr_byte = 8'd0;
    endcase
  end

  // buffer ports
  logic          buf_we;
  logic [BW-1:0] buf_wa, buf_ra;
  logic [7:0]    buf_wd;
  logic          buf_re;
  always_comb begin
    buf_we = 1'b0;
    buf_wa = pos_q[BW-1:0];
    buf_wd = val_q;
    if (cmd_i.exec && is_dwrite && in_buf) buf_we = 1'b1;
    if (cmd_i.copy_wr && mode_q != COPY_BUF2DISK) begin
      buf_we = 1'b1;
      buf_wa = widx[BW-1:0];
      buf_wd = (mode_q == COPY_ADDR) ? addr_byte : disk_rd_q;
    end
    buf_re = (cmd_i.exec && status_o.need_rdbuf) ||
             (cmd_i.copy_rd && mode_q == COPY_BUF2DISK);
    buf_ra = cmd_i.exec ? pos_q[BW-1:0] : copy_idx_i[BW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    if (buf_re) buf_rd_q <= buf_mem[buf_ra];
  end

  // disk image ports
  logic           disk_we, disk_re;
  logic [DAW-1:0] disk_wa, disk_ra;
  logic [7:0]     disk_wd;
  always_comb begin
    disk_we = cmd_i.exec && (kind_q == KIND_LOAD) && (32'(addr_q) < 32'(DISK_BYTES));
    disk_wa = DAW'(addr_q);
    disk_wd = byte_q;
    if (cmd_i.copy_wr && mode_q == COPY_BUF2DISK) begin
      disk_we = 1'b1;
      disk_wa = off_q + DAW'(widx);
      disk_wd = buf_rd_q;
    end
    disk_re = cmd_i.copy_rd && mode_q == COPY_DISK2BUF;
    disk_ra = off_q + DAW'(copy_idx_i);
  end

  always_ff @(posedge clk_i) begin
    if (disk_we) disk_mem[disk_wa] <= disk_wd;
    if (disk_re) disk_rd_q <= disk_mem[disk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= kind_i;
      reg_q   <= reg_index_i;
      val_q   <= write_value_i;
      side_q  <= side_i;
      drive_q <= drive_i;
      addr_q  <= image_address_i;
      byte_q  <= image_byte_i;
    end
    if (cmd_i.exec) begin
      off_q  <= DAW'(off_w);
      mode_q <= status_o.mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_present_q <= 1'b0;
      track_count_q  <= 7'd80;
      head_count_q   <= 2'd2;
      spt_q          <= 4'd9;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DISK:    disk_present_q <= cfg_data_i[0];
        CFG_TRACKS:  track_count_q  <= cfg_data_i[6:0];
        CFG_HEADS:   head_count_q   <= cfg_data_i[1:0];
        CFG_SECTORS: spt_q          <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= 8'd0; sector_q <= 8'd1; data_q <= 8'd0; rd_q <= 8'd0;
      nf_q <= 1'b0; drq_q <= 1'b0; irq_q <= 1'b0; busy_q <= 1'b0;
      t1_q <= 1'b1; wr_mode_q <= 1'b0; toggle_q <= 1'b0;
      len_q <= '0; pos_q <= '0;
    end else if (cmd_i.exec) begin
      rd_q <= 8'd0;
      case (kind_q)
        KIND_READ: begin
          case (reg_q)
            REG_CMD: begin
              rd_q <= status_v;
              if (t1_q) toggle_q <= !toggle_q;
            end
            REG_TRACK:  rd_q <= track_q;
            REG_SECTOR: rd_q <= sector_q;
            default: if (!in_buf) rd_q <= data_q;
          endcase
        end
        KIND_WRITE: begin
          case (reg_q)
            REG_CMD: begin
              drq_q <= 1'b0;
              if (!cmdn[3]) begin
                case (cmdn)
                  CMD_RESTORE: track_q <= 8'd0;
                  CMD_SEEK:    track_q <= data_q;
                  CMD_STEP_IN_A, CMD_STEP_IN_B: begin
                    if (track_q < 8'(StepLimit)) track_q <= track_q + 8'd1;
                  end
                  CMD_STEP_OUT_A, CMD_STEP_OUT_B, CMD_STEP_OUT_C: begin
                    if (track_q != 8'd0) track_q <= track_q - 8'd1;
                  end
                  default: ;
                endcase
                t1_q <= 1'b1; busy_q <= 1'b0; irq_q <= 1'b1; nf_q <= 1'b0;
              end else if (cmd_xfer) begin
                t1_q <= 1'b0;
                if (!loc_ok) begin
                  busy_q <= 1'b0; irq_q <= 1'b1; wr_mode_q <= 1'b0; nf_q <= 1'b1;
                end else begin
                  wr_mode_q <= (cmdn == CMD_WRITE);
                  len_q <= (cmdn == CMD_RD_ADDR) ? CW'(AddrFieldLen) : CW'(SECTOR_BYTES);
                  pos_q <= '0; busy_q <= 1'b1; drq_q <= 1'b1; irq_q <= 1'b0; nf_q <= 1'b0;
                end
              end else if (cmdn == CMD_FORCE_IRQ) begin
                busy_q <= 1'b0; t1_q <= 1'b1; irq_q <= |val_q[3:0];
              end else begin
                t1_q <= 1'b0; busy_q <= 1'b0; irq_q <= 1'b1; wr_mode_q <= 1'b0;
                nf_q <= 1'b1;
              end
            end
            REG_TRACK:  track_q <= val_q;
            REG_SECTOR: sector_q <= val_q;
            default: begin
              data_q <= val_q;
              if (wr_mode_q) begin
                pos_q <= pos_new;
                if (pos_new >= len_q) begin
                  t1_q <= 1'b0; busy_q <= 1'b0; drq_q <= 1'b0; irq_q <= 1'b1;
                  wr_mode_q <= 1'b0; nf_q <= 1'b0;
                end else begin
                  drq_q <= 1'b1;
                end
              end
            end
          endcase
        end
        default: ;
      endcase
    end else if (cmd_i.rd_fin) begin
      data_q <= buf_rd_q;
      rd_q   <= buf_rd_q;
      pos_q  <= pos_inc;
      if (pos_inc >= len_q) begin
        t1_q <= 1'b0; busy_q <= 1'b0; drq_q <= 1'b0; irq_q <= 1'b1;
        wr_mode_q <= 1'b0; nf_q <= 1'b0;
      end else begin
        drq_q <= 1'b1;
      end
    end
  end

  assign read_data_o = rd_q;
  assign irq_line_o  = irq_q;
  assign drq_line_o  = drq_q;
  assign busy_flag_o = busy_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for floppy_controller_register_model_unit.
// Predicts each result beat from a behavioural copy of the controller and checks
// it field by field; depends on fcrm_pkg and the unit itself.
`timescale 1ns / 100ps

module tb_top;
  import fcrm_pkg::*;

  localparam int SECTOR = 512;
  localparam int DISK   = 1048576;
  localparam logic [7:0] SIZE_CODE = 8'd2;  // 128 << 2 == 512

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
    logic       drq;
    logic       busy;
  } fdc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [1:0]  reg_index_i = '0;
  logic [7:0]  write_value_i = '0;
  logic        side_i = 1'b0;
  logic [1:0]  drive_i = '0;
  logic [19:0] image_address_i = '0;
  logic [7:0]  image_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_data_o;
  logic        irq_line_o;
  logic        drq_line_o;
  logic        busy_flag_o;

  floppy_controller_register_model_unit u_dut (.*);

  always #10 clk_i = ~clk_i;

  // controller copy
  int          geo_present, geo_tracks, geo_heads, geo_spt;
  logic [7:0]  trk_q, sec_q, dat_q;
  bit          rnf_q, drq_q, irq_q, busy_q, type1_q, wrmode_q, index_q;
  logic [7:0]  xfer_buf [SECTOR];
  bit          xfer_valid [SECTOR];
  int          xfer_len, xfer_pos;
  logic [7:0]  image_mem [int];

  fdc_result_t pending_q[$];
  int          n_errors, n_items, n_results, n_sector_reads, n_commits;
  bit          tx_eager, rx_eager, hold_request;
  int          rx_stall, hold_left;

  function automatic bit find_sector(input bit sd, input logic [1:0] drv, output int off);
    longint o;
    off = 0;
    if (geo_present == 0 || drv != 0) return 0;
    if (trk_q >= geo_tracks || sd >= geo_heads) return 0;
    if (sec_q < 1 || sec_q > geo_spt) return 0;
    o = ((longint'(trk_q) * geo_heads + sd) * geo_spt + (sec_q - 1)) * SECTOR;
    if (o + SECTOR > DISK) return 0;
    off = int'(o);
    return 1;
  endfunction

  function automatic bit sector_known(input int off);
    for (int i = 0; i < SECTOR; i++)
      if (!image_mem.exists(off + i)) return 0;
    return 1;
  endfunction

  function automatic void finish_xfer(input bit rnf);
    type1_q = 0; busy_q = 0; drq_q = 0; irq_q = 1; wrmode_q = 0; rnf_q = rnf;
  endfunction

  function automatic void start_xfer(input int len);
    xfer_len = len; xfer_pos = 0; busy_q = 1; drq_q = 1; irq_q = 0; rnf_q = 0;
  endfunction

  function automatic void run_command(input logic [7:0] v, input bit sd,
                                      input logic [1:0] drv);
    logic [3:0] op;
    int off;
    op = v[7:4];
    busy_q = 1; drq_q = 0; irq_q = 0;
    if (!op[3]) begin
      if (op == CMD_RESTORE) trk_q = 0;
      else if (op == CMD_SEEK) trk_q = dat_q;
      else if (op == CMD_STEP_IN_A || op == CMD_STEP_IN_B) begin
        if (trk_q < StepLimit) trk_q++;
      end else if (op == CMD_STEP_OUT_A || op == CMD_STEP_OUT_B || op == CMD_STEP_OUT_C) begin
        if (trk_q > 0) trk_q--;
      end
      type1_q = 1; busy_q = 0; drq_q = 0; irq_q = 1; rnf_q = 0;
    end else if (op == CMD_READ || op == CMD_WRITE || op == CMD_RD_ADDR) begin
      type1_q = 0;
      wrmode_q = (op == CMD_WRITE);
      if (!find_sector(sd, drv, off)) begin
        finish_xfer(1);
      end else if (op == CMD_READ) begin
        for (int i = 0; i < SECTOR; i++) begin
          xfer_buf[i] = image_mem[off + i];
          xfer_valid[i] = 1;
        end
        n_sector_reads++;
        start_xfer(SECTOR);
      end else if (op == CMD_WRITE) begin
        for (int i = 0; i < SECTOR; i++) xfer_valid[i] = 0;
        start_xfer(SECTOR);
      end else begin
        xfer_buf[0] = trk_q; xfer_buf[1] = {7'd0, sd}; xfer_buf[2] = sec_q;
        xfer_buf[3] = SIZE_CODE; xfer_buf[4] = 0; xfer_buf[5] = 0;
        for (int i = 0; i < 6; i++) xfer_valid[i] = 1;
        start_xfer(AddrFieldLen);
      end
    end else if (op == CMD_FORCE_IRQ) begin
      busy_q = 0; type1_q = 1; drq_q = 0; irq_q = (v[3:0] != 0);
    end else begin
      finish_xfer(1);
    end
  endfunction

  function automatic fdc_result_t predict_beat(input logic [1:0] k, input logic [1:0] r,
      input logic [7:0] v, input bit sd, input logic [1:0] drv, input logic [19:0] a,
      input logic [7:0] b);
    fdc_result_t res;
    int off;
    res.rd = 0;
    if (k == KIND_READ) begin
      case (r)
        REG_CMD: begin
          if (geo_present == 0 || drv != 0) res.rd[7] = 1;
          res.rd[0] = busy_q;
          if (type1_q) begin
            res.rd[2] = (trk_q == 0);
            res.rd[5] = 1;
            index_q = !index_q;
            res.rd[1] = index_q;
          end else begin
            res.rd[1] = drq_q;
            res.rd[4] = rnf_q;
          end
        end
        REG_TRACK: res.rd = trk_q;
        REG_SECTOR: res.rd = sec_q;
        default: begin
          if (xfer_pos < xfer_len && xfer_pos < SECTOR) begin
            dat_q = xfer_buf[xfer_pos++];
            if (xfer_pos >= xfer_len) finish_xfer(0);
            else drq_q = 1;
          end
          res.rd = dat_q;
        end
      endcase
    end else if (k == KIND_WRITE) begin
      case (r)
        REG_CMD: run_command(v, sd, drv);
        REG_TRACK: trk_q = v;
        REG_SECTOR: sec_q = v;
        default: begin
          dat_q = v;
          if (wrmode_q) begin
            if (xfer_pos < xfer_len && xfer_pos < SECTOR) begin
              xfer_buf[xfer_pos] = v;
              xfer_valid[xfer_pos++] = 1;
            end
            if (xfer_pos >= xfer_len) begin
              if (find_sector(sd, drv, off)) begin
                for (int i = 0; i < SECTOR; i++)
                  if (xfer_valid[i]) image_mem[off + i] = xfer_buf[i];
                  else image_mem.delete(off + i);
                n_commits++;
              end
              finish_xfer(0);
            end else begin
              drq_q = 1;
            end
          end
        end
      endcase
    end else if (k == KIND_LOAD) begin
      image_mem[int'(a)] = b;
    end
    res.irq = irq_q; res.drq = drq_q; res.busy = busy_q;
    return res;
  endfunction

  // Steer away from reads of image bytes or buffer entries never written.
  function automatic bit touches_unwritten(input logic [1:0] k, input logic [1:0] r,
      input logic [7:0] v, input bit sd, input logic [1:0] drv);
    int off;
    if (k == KIND_WRITE && r == REG_CMD && v[7:4] == CMD_READ && find_sector(sd, drv, off))
      return !sector_known(off);
    if (k == KIND_READ && r == REG_DATA && xfer_pos < xfer_len && xfer_pos < SECTOR)
      return !xfer_valid[xfer_pos];
    return 0;
  endfunction

  task automatic send_beat(input logic [1:0] k, input logic [1:0] r, input logic [7:0] v,
      input bit sd = 0, input logic [1:0] drv = 0, input logic [19:0] a = 0,
      input logic [7:0] b = 0);
    int gap;
    if (touches_unwritten(k, r, v, sd, drv)) begin
      k = KIND_READ; r = REG_TRACK;
    end
    kind_i <= k; reg_index_i <= r; write_value_i <= v; side_i <= sd; drive_i <= drv;
    image_address_i <= a; image_byte_i <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(predict_beat(k, r, v, sd, drv, a, b));
    n_items++;
    if ($urandom_range(0, 99) == 0) tx_eager = !tx_eager;
    gap = tx_eager ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wr_reg(input logic [1:0] r, input logic [7:0] v, input bit sd = 0,
                        input logic [1:0] drv = 0);
    send_beat(KIND_WRITE, r, v, sd, drv);
  endtask

  task automatic rd_reg(input logic [1:0] r, input logic [1:0] drv = 0);
    send_beat(KIND_READ, r, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), drv);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int present, input int tracks, input int heads,
                              input int spt);
    logic [7:0] vals [4];
    drain();
    vals = '{present[7:0], tracks[7:0], heads[7:0], spt[7:0]};
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= i[1:0]; cfg_data_i <= vals[i]; cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    geo_present = present & 1; geo_tracks = tracks & 8'h7f;
    geo_heads = heads & 3; geo_spt = spt & 8'h0f;
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("tb_top: mismatch on %s: got %0h, want %0h", what, got, want);
    n_errors++;
  endtask

  // sink side: random stalls, long hold-off on request, and the check of each beat
  always @(posedge clk_i or negedge rst_ni) begin
    fdc_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (pending_q.size() == 0) begin
          report("unexpected beat", read_data_o, 0);
        end else begin
          want = pending_q.pop_front();
          if (read_data_o !== want.rd) report("read_data", read_data_o, want.rd);
          if (irq_line_o !== want.irq) report("irq_line", irq_line_o, want.irq);
          if (drq_line_o !== want.drq) report("drq_line", drq_line_o, want.drq);
          if (busy_flag_o !== want.busy) report("busy_flag", busy_flag_o, want.busy);
        end
        if ($urandom_range(0, 99) == 0) rx_eager = !rx_eager;
        rx_stall = rx_eager ? 0 : $urandom_range(0, 16);
      end
      if (hold_request) begin
        hold_left = 300;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic test_reset_values;
    rd_reg(REG_CMD); rd_reg(REG_CMD, 2'd3); rd_reg(REG_TRACK); rd_reg(REG_SECTOR);
    rd_reg(REG_DATA);
  endtask

  task automatic test_commands_without_disk;
    for (int op = 0; op < 16; op++) begin
      wr_reg(REG_CMD, {op[3:0], op[3:0] ^ 4'hf});
      if (op[0]) rd_reg(REG_CMD);
    end
    send_beat(2'd3, REG_DATA, 8'hff, 1'b1, 2'd3, 20'hfffff, 8'hff);
    send_beat(KIND_LOAD, REG_CMD, 8'h00, 1'b0, 2'd0, 20'hfffff, 8'hff);
  endtask

  task automatic test_step_limits;
    wr_reg(REG_TRACK, 8'd79);
    wr_reg(REG_CMD, 8'h40); wr_reg(REG_CMD, 8'h60); rd_reg(REG_TRACK);
    wr_reg(REG_TRACK, 8'd0); wr_reg(REG_CMD, 8'h2f); rd_reg(REG_CMD);
    wr_reg(REG_DATA, 8'hff); wr_reg(REG_CMD, 8'h10); rd_reg(REG_TRACK);
    wr_reg(REG_CMD, 8'hd0); rd_reg(REG_CMD); wr_reg(REG_CMD, 8'hd8);
    wr_reg(REG_CMD, 8'h00); rd_reg(REG_CMD, 2'd1);
  endtask

  task automatic test_sector_round_trip;
    wr_reg(REG_TRACK, 8'd0); wr_reg(REG_SECTOR, 8'd1);
    wr_reg(REG_CMD, 8'ha0);
    for (int i = 0; i < SECTOR; i++) wr_reg(REG_DATA, 8'($urandom_range(0, 255)));
    rd_reg(REG_CMD);
    wr_reg(REG_CMD, 8'h80);
    for (int i = 0; i < SECTOR; i++) rd_reg(REG_DATA);
    rd_reg(REG_CMD); rd_reg(REG_DATA);
    wr_reg(REG_SECTOR, 8'd9); wr_reg(REG_CMD, 8'hc0, 1'b1);
    for (int i = 0; i < 7; i++) rd_reg(REG_DATA);
    wr_reg(REG_SECTOR, 8'd10); wr_reg(REG_CMD, 8'h80); rd_reg(REG_CMD);
    wr_reg(REG_SECTOR, 8'd1); wr_reg(REG_CMD, 8'h80, 1'b0, 2'd2); rd_reg(REG_CMD, 2'd2);
  endtask

  task automatic test_backpressure;
    drain();
    hold_request = 1;
    tx_eager = 1;
    for (int i = 0; i < 20; i++) rd_reg(i[1:0]);
    tx_eager = 0;
    drain();
  endtask

  task automatic random_sequence;
    int n;
    case ($urandom_range(0, 9))
      0: wr_reg(REG_CMD, {1'b0, 3'($urandom_range(0, 7)), 4'($urandom)},
                1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      1: wr_reg(2'($urandom_range(1, 2)),
                8'($urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom_range(0, 255)));
      2: rd_reg(2'($urandom_range(0, 3)),
                2'($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0));
      3: begin
        wr_reg(REG_SECTOR, 8'($urandom_range(0, 10)));
        wr_reg(REG_CMD, 8'hc0 | 8'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 8);
        repeat (n) rd_reg(REG_DATA);
      end
      4: begin
        wr_reg(REG_TRACK, 8'd0); wr_reg(REG_SECTOR, 8'd1);
        wr_reg(REG_CMD, 8'h80 | 8'($urandom_range(0, 15)), 1'b0,
               2'($urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : 0));
        n = $urandom_range(0, 12);
        repeat (n) rd_reg(REG_DATA);
        if ($urandom_range(0, 1)) rd_reg(REG_CMD);
        wr_reg(REG_CMD, 8'hd0 | 8'($urandom_range(0, 15)));
      end
      5: begin
        wr_reg(REG_CMD, 8'ha0 | 8'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 6);
        repeat (n) wr_reg(REG_DATA, 8'($urandom_range(0, 255)));
        wr_reg(REG_CMD, 8'hd0 | 8'($urandom_range(0, 15)));
      end
      6: begin
        case ($urandom_range(0, 3))
          0: n = 9;
          1: n = 11;
          2: n = 14;
          default: n = 15;
        endcase
        wr_reg(REG_CMD, {n[3:0], 4'($urandom)}, 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)));
        rd_reg(REG_CMD);
      end
      7: send_beat(KIND_LOAD, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   20'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                            : $urandom_range(0, 20'hfffff)),
                   8'($urandom_range(0, 255)));
      8: send_beat(2'd3, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   20'($urandom_range(0, 20'hfffff)), 8'($urandom_range(0, 255)));
      default: begin
        wr_reg(REG_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        rd_reg(REG_DATA);
      end
    endcase
  endtask

  task automatic test_random(input int count);
    int stop_at;
    stop_at = n_items + count;
    while (n_items < stop_at) random_sequence();
  endtask

  initial begin
    geo_present = 0; geo_tracks = 80; geo_heads = 2; geo_spt = 9;
    trk_q = 0; sec_q = 1; dat_q = 0;
    rnf_q = 0; drq_q = 0; irq_q = 0; busy_q = 0; type1_q = 1; wrmode_q = 0; index_q = 0;
    xfer_len = 0; xfer_pos = 0;
    for (int i = 0; i < SECTOR; i++) begin
      xfer_buf[i] = 0; xfer_valid[i] = 0;
    end
    tx_eager = 0; rx_eager = 0; hold_request = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_commands_without_disk();
    set_geometry(1, 82, 2, 9);
    test_step_limits();
    test_sector_round_trip();
    test_backpressure();
    test_random(220);
    set_geometry(1, 1, 1, 1);
    test_random(120);
    set_geometry(8'hff, 8'hff, 8'hff, 8'hff);
    test_random(100);
    set_geometry(0, 80, 2, 9);
    test_random(50);

    drain();
    repeat (600) @(posedge clk_i);
    $display("tb_top: %0d beats sent, %0d checked, %0d sector reads, %0d sector commits,",
             n_items, n_results, n_sector_reads, n_commits);
    $display("tb_top: four geometry settings including out-of-range values");
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== floppy_controller_register_model_unit.f =====
src/fcrm_pkg.sv
src/fcrm_ctrl.sv
src/fcrm_datapath.sv
src/floppy_controller_register_model_unit.sv
sim/tb_top.sv
